@@ rtl/core/clle_pkg.sv @@
// ----------------------------------------------------------------------------
// clle_pkg
// Shared types, constants and the control store of the linked list engine.
// ----------------------------------------------------------------------------
package clle_pkg;

    localparam int NODES    = 16;
    localparam int IDX_W    = $clog2(NODES);
    localparam int LINK_W   = $clog2(NODES + 1);
    localparam int FUNC_W   = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 4;

    localparam logic [FUNC_W-1:0] FN_INS_HEAD = 3'd0;
    localparam logic [FUNC_W-1:0] FN_INS_TAIL = 3'd1;
    localparam logic [FUNC_W-1:0] FN_INS_UNIQ = 3'd2;
    localparam logic [FUNC_W-1:0] FN_DELETE   = 3'd3;
    localparam logic [FUNC_W-1:0] FN_FIND     = 3'd4;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE    = 2'd0,
        ST_FULL    = 2'd1,
        ST_PRESENT = 2'd2,
        ST_ABSENT  = 2'd3
    } status_t;

    // control store addresses
    typedef enum logic [3:0] {
        U_IDLE    = 4'd0,
        U_W_FIND  = 4'd1,
        U_W_DEL   = 4'd2,
        U_W_UNIQ  = 4'd3,
        U_ALLOC_H = 4'd4,
        U_ALLOC_T = 4'd5,
        U_W_TAIL  = 4'd6,
        U_LINK_T  = 4'd7,
        U_UNLINK  = 4'd8,
        U_E_CUR   = 4'd9,
        U_E_NEW   = 4'd10,
        U_E_FULL  = 4'd11,
        U_E_PRES  = 4'd12,
        U_E_ABS   = 4'd13
    } upc_t;

    typedef enum logic [2:0] {
        C_NEVER    = 3'd0,
        C_NO_INPUT = 3'd1,
        C_WALK_END = 3'd2,
        C_MATCH    = 3'd3,
        C_FULL     = 3'd4,
        C_OUT_BUSY = 3'd5
    } cond_t;

    typedef enum logic [2:0] {
        ACT_NOP        = 3'd0,
        ACT_LOAD       = 3'd1,
        ACT_STEP       = 3'd2,
        ACT_ALLOC      = 3'd3,
        ACT_ALLOC_HEAD = 3'd4,
        ACT_LINK_TAIL  = 3'd5,
        ACT_UNLINK     = 3'd6,
        ACT_EMIT       = 3'd7
    } act_t;

    typedef enum logic {
        NX_JUMP = 1'b0,
        NX_FUNC = 1'b1
    } nxt_t;

    // c1 hit wins, then c2; else act runs, next is t3 or the func entry
    typedef struct packed {
        cond_t   c1;
        upc_t    t1;
        cond_t   c2;
        upc_t    t2;
        act_t    act;
        nxt_t    nmode;
        upc_t    t3;
        status_t st;
        logic    slot_new;
    } uword_t;

    typedef struct packed {
        act_t    act;
        status_t st;
        logic    slot_new;
        logic    idle;
    } ctrl_t;

    typedef struct packed {
        logic              in_valid;
        logic              walk_end;
        logic              match;
        logic              full;
        logic              out_busy;
        logic [FUNC_W-1:0] func;
    } flags_t;

    function automatic uword_t uw(cond_t c1, upc_t t1, cond_t c2, upc_t t2, act_t act,
                                  nxt_t nmode, upc_t t3, status_t st, logic slot_new);
        uword_t w;
        w.c1       = c1;
        w.t1       = t1;
        w.c2       = c2;
        w.t2       = t2;
        w.act      = act;
        w.nmode    = nmode;
        w.t3       = t3;
        w.st       = st;
        w.slot_new = slot_new;
        return w;
    endfunction

    function automatic uword_t ucode_rom(upc_t a);
        uword_t w;
        unique case (a)
            U_IDLE:    w = uw(C_NO_INPUT, U_IDLE,  C_NEVER, U_IDLE,
                              ACT_LOAD, NX_FUNC, U_IDLE, ST_DONE, 1'b0);
            U_W_FIND:  w = uw(C_WALK_END, U_E_ABS, C_MATCH, U_E_CUR,
                              ACT_STEP, NX_JUMP, U_W_FIND, ST_DONE, 1'b0);
            U_W_DEL:   w = uw(C_WALK_END, U_E_ABS, C_MATCH, U_UNLINK,
                              ACT_STEP, NX_JUMP, U_W_DEL, ST_DONE, 1'b0);
            U_W_UNIQ:  w = uw(C_WALK_END, U_ALLOC_H, C_MATCH, U_E_PRES,
                              ACT_STEP, NX_JUMP, U_W_UNIQ, ST_DONE, 1'b0);
            U_ALLOC_H: w = uw(C_FULL, U_E_FULL, C_NEVER, U_IDLE,
                              ACT_ALLOC_HEAD, NX_JUMP, U_E_NEW, ST_DONE, 1'b0);
            U_ALLOC_T: w = uw(C_FULL, U_E_FULL, C_NEVER, U_IDLE,
                              ACT_ALLOC, NX_JUMP, U_W_TAIL, ST_DONE, 1'b0);
            U_W_TAIL:  w = uw(C_WALK_END, U_LINK_T, C_NEVER, U_IDLE,
                              ACT_STEP, NX_JUMP, U_W_TAIL, ST_DONE, 1'b0);
            U_LINK_T:  w = uw(C_NEVER, U_IDLE, C_NEVER, U_IDLE,
                              ACT_LINK_TAIL, NX_JUMP, U_E_NEW, ST_DONE, 1'b0);
            U_UNLINK:  w = uw(C_NEVER, U_IDLE, C_NEVER, U_IDLE,
                              ACT_UNLINK, NX_JUMP, U_E_CUR, ST_DONE, 1'b0);
            U_E_CUR:   w = uw(C_OUT_BUSY, U_E_CUR, C_NEVER, U_IDLE,
                              ACT_EMIT, NX_JUMP, U_IDLE, ST_DONE, 1'b0);
            U_E_NEW:   w = uw(C_OUT_BUSY, U_E_NEW, C_NEVER, U_IDLE,
                              ACT_EMIT, NX_JUMP, U_IDLE, ST_DONE, 1'b1);
            U_E_FULL:  w = uw(C_OUT_BUSY, U_E_FULL, C_NEVER, U_IDLE,
                              ACT_EMIT, NX_JUMP, U_IDLE, ST_FULL, 1'b0);
            U_E_PRES:  w = uw(C_OUT_BUSY, U_E_PRES, C_NEVER, U_IDLE,
                              ACT_EMIT, NX_JUMP, U_IDLE, ST_PRESENT, 1'b0);
            U_E_ABS:   w = uw(C_OUT_BUSY, U_E_ABS, C_NEVER, U_IDLE,
                              ACT_EMIT, NX_JUMP, U_IDLE, ST_ABSENT, 1'b0);
            default:   w = uw(C_NEVER, U_IDLE, C_NEVER, U_IDLE,
                              ACT_NOP, NX_JUMP, U_IDLE, ST_DONE, 1'b0);
        endcase
        return w;
    endfunction

endpackage

@@ rtl/core/clle_req_if.sv @@
// ----------------------------------------------------------------------------
// clle_req_if
// Request channel: function code and element value.
// ----------------------------------------------------------------------------
interface clle_req_if;
    import clle_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [FUNC_W-1:0]          func;
    logic signed [VALUE_W-1:0]  value;

    modport source (output valid, func, value, input ready);
    modport sink   (input valid, func, value, output ready);
endinterface

@@ rtl/core/clle_rsp_if.sv @@
// ----------------------------------------------------------------------------
// clle_rsp_if
// Response channel: status and node index.
// ----------------------------------------------------------------------------
interface clle_rsp_if;
    import clle_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;

    modport source (output valid, status, slot, input ready);
    modport sink   (input valid, status, slot, output ready);
endinterface

@@ rtl/core/clle_seq.sv @@
// ----------------------------------------------------------------------------
// clle_seq
// Microprogram sequencer: address register, control store, two-way conditional
// jump plus a default jump target or function dispatch.
// ----------------------------------------------------------------------------
module clle_seq (
    input  logic            clk,
    input  logic            rst_n,
    input  clle_pkg::flags_t flags,
    output clle_pkg::ctrl_t  ctrl
);
    import clle_pkg::*;

    upc_t   upc_reg;
    upc_t   upc_next;
    uword_t word;
    logic   hit1;
    logic   hit2;

    function automatic logic cond_eval(cond_t c, flags_t f);
        logic r;
        unique case (c)
            C_NEVER:    r = 1'b0;
            C_NO_INPUT: r = !f.in_valid;
            C_WALK_END: r = f.walk_end;
            C_MATCH:    r = f.match;
            C_FULL:     r = f.full;
            C_OUT_BUSY: r = f.out_busy;
            default:    r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic upc_t func_entry(logic [FUNC_W-1:0] fn);
        upc_t e;
        unique case (fn)
            FN_INS_HEAD: e = U_ALLOC_H;
            FN_INS_TAIL: e = U_ALLOC_T;
            FN_INS_UNIQ: e = U_W_UNIQ;
            FN_DELETE:   e = U_W_DEL;
            FN_FIND:     e = U_W_FIND;
            default:     e = U_E_ABS;
        endcase
        return e;
    endfunction

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            upc_reg <= U_IDLE;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

    always_comb begin
        word = ucode_rom(upc_reg);
        hit1 = cond_eval(word.c1, flags);
        hit2 = cond_eval(word.c2, flags);

        ctrl.st       = word.st;
        ctrl.slot_new = word.slot_new;
        ctrl.idle     = (upc_reg == U_IDLE);
        ctrl.act      = ACT_NOP;

        priority if (hit1)
        begin
            upc_next = word.t1;
        end
        else if (hit2)
        begin
            upc_next = word.t2;
        end
        else
        begin
            ctrl.act = word.act;
            // dispatch reads the function code from the request being taken
            upc_next = (word.nmode == NX_FUNC) ? func_entry(flags.func) : word.t3;
        end
    end

endmodule

@@ rtl/core/clle_dp.sv @@
// ----------------------------------------------------------------------------
// clle_dp
// Datapath: node store, in-use bits, list walk registers, free-node
// encoder and the result register.
// ----------------------------------------------------------------------------
module clle_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  clle_pkg::ctrl_t                   ctrl,
    output clle_pkg::flags_t                  flags,
    input  logic                              in_valid,
    input  logic [clle_pkg::FUNC_W-1:0]       in_func,
    input  logic signed [clle_pkg::VALUE_W-1:0] in_value,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [clle_pkg::STATUS_W-1:0]     out_status,
    output logic [clle_pkg::SLOT_W-1:0]       out_slot
);
    import clle_pkg::*;

    localparam logic [LINK_W-1:0] NIL = LINK_W'(NODES);

    logic [VALUE_W-1:0]  node_value [NODES];
    logic [LINK_W-1:0]   node_link  [NODES];
    logic [NODES-1:0]    used_reg;

    logic [FUNC_W-1:0]   func_reg;
    logic [VALUE_W-1:0]  value_reg;
    logic [LINK_W-1:0]   head_reg;
    logic [LINK_W-1:0]   cur_reg;
    logic [LINK_W-1:0]   prev_reg;
    logic [LINK_W-1:0]   steps_reg;
    logic [IDX_W-1:0]    new_reg;

    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [SLOT_W-1:0]   out_slot_reg;

    logic [IDX_W-1:0]    cur_idx;
    logic [IDX_W-1:0]    prev_idx;
    logic [IDX_W-1:0]    free_idx;
    logic [LINK_W-1:0]   cur_link;

    logic                lnk_we;
    logic [IDX_W-1:0]    lnk_addr;
    logic [LINK_W-1:0]   lnk_data;

    assign cur_idx  = cur_reg[IDX_W-1:0];
    assign prev_idx = prev_reg[IDX_W-1:0];
    assign cur_link = node_link[cur_idx];

    // lowest free node
    always_comb begin
        free_idx = '0;
        for (int i = NODES - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_idx = IDX_W'(i);
            end
        end
    end

    always_comb begin
        flags.in_valid = in_valid;
        flags.walk_end = !((steps_reg < NIL) && (cur_reg < NIL));
        flags.match    = (node_value[cur_idx] == value_reg);
        flags.full     = &used_reg;
        flags.out_busy = out_valid_reg && !out_ready;
        // dispatch happens in the accepting cycle, so pass the live code
        flags.func     = ctrl.idle ? in_func : func_reg;
    end

    // single link write port
    always_comb begin
        lnk_we   = 1'b0;
        lnk_addr = free_idx;
        lnk_data = NIL;
        unique case (ctrl.act)
            ACT_ALLOC:
            begin
                lnk_we   = 1'b1;
                lnk_addr = free_idx;
                lnk_data = NIL;
            end
            ACT_ALLOC_HEAD:
            begin
                lnk_we   = 1'b1;
                lnk_addr = free_idx;
                lnk_data = head_reg;
            end
            ACT_LINK_TAIL:
            begin
                lnk_we   = (prev_reg != NIL);
                lnk_addr = prev_idx;
                lnk_data = LINK_W'(new_reg);
            end
            ACT_UNLINK:
            begin
                lnk_we   = (prev_reg != NIL);
                lnk_addr = prev_idx;
                lnk_data = cur_link;
            end
            default:
            begin
                lnk_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk) begin
        if (lnk_we)
        begin
            node_link[lnk_addr] <= lnk_data;
        end
        if ((ctrl.act == ACT_ALLOC) || (ctrl.act == ACT_ALLOC_HEAD))
        begin
            node_value[free_idx] <= value_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (ctrl.act == ACT_LOAD)
        begin
            func_reg  <= in_func;
            value_reg <= in_value;
        end
        if ((ctrl.act == ACT_ALLOC) || (ctrl.act == ACT_ALLOC_HEAD))
        begin
            new_reg <= free_idx;
        end
        if (ctrl.act == ACT_EMIT)
        begin
            out_status_reg <= ctrl.st;
            if (ctrl.st != ST_DONE)
            begin
                out_slot_reg <= '0;
            end
            else if (ctrl.slot_new)
            begin
                out_slot_reg <= SLOT_W'(new_reg);
            end
            else
            begin
                out_slot_reg <= SLOT_W'(cur_idx);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            head_reg      <= NIL;
            cur_reg       <= NIL;
            prev_reg      <= NIL;
            steps_reg     <= '0;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (ctrl.act)
                ACT_LOAD:
                begin
                    cur_reg   <= head_reg;
                    prev_reg  <= NIL;
                    steps_reg <= '0;
                end
                ACT_STEP:
                begin
                    prev_reg  <= cur_reg;
                    cur_reg   <= cur_link;
                    steps_reg <= steps_reg + 1'b1;
                end
                ACT_ALLOC:
                begin
                    used_reg[free_idx] <= 1'b1;
                end
                ACT_ALLOC_HEAD:
                begin
                    used_reg[free_idx] <= 1'b1;
                    head_reg           <= LINK_W'(free_idx);
                end
                ACT_LINK_TAIL:
                begin
                    // empty list: new node becomes the head
                    if (prev_reg == NIL)
                    begin
                        head_reg <= LINK_W'(new_reg);
                    end
                end
                ACT_UNLINK:
                begin
                    used_reg[cur_idx] <= 1'b0;
                    if (prev_reg == NIL)
                    begin
                        head_reg <= cur_link;
                    end
                end
                default:
                begin
                end
            endcase

            if (ctrl.act == ACT_EMIT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_slot   = out_slot_reg;

endmodule

@@ rtl/core/cursor_linked_list_engine_unit.sv @@
// Operation: a request is taken in the idle state; a head insert then
//   allocates a node and emits the result, while tail insert, unique insert,
//   delete and find walk the list, one node per cycle, before the result is
//   emitted. One request at a time: no new request is taken until the result
//   has been emitted, and a busy response channel holds the emit.
// Reset: list empty, every node free; node values and links are not cleared.
// ----------------------------------------------------------------------------
// cursor_linked_list_engine_unit
// Singly linked list in a fixed node store, run by a microprogrammed
// sequencer over a walk datapath.
// ----------------------------------------------------------------------------
module cursor_linked_list_engine_unit (
    input  logic clk,
    input  logic rst_n,
    clle_req_if.sink   req,
    clle_rsp_if.source rsp
);
    import clle_pkg::*;

    ctrl_t  ctrl;
    flags_t flags;

    assign req.ready = ctrl.idle;

    clle_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctrl  (ctrl)
    );

    clle_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .flags      (flags),
        .in_valid   (req.valid),
        .in_func    (req.func),
        .in_value   (req.value),
        .out_valid  (rsp.valid),
        .out_ready  (rsp.ready),
        .out_status (rsp.status),
        .out_slot   (rsp.slot)
    );

endmodule
